[rtl/asrst_pkg.sv]
// Shared constants and types for the alternating-sign range-sum tree core.
// No dependencies; imported by alternating_sign_range_sum_tree_core.
package asrst_pkg;

   // Tree geometry
   localparam int LEAVES = 1024;
   localparam int LEVELS = $clog2(LEAVES);
   localparam int NODES  = 2 * LEAVES;
   localparam int ADDR_W = LEVELS + 1;   // node address into the sum store
   localparam int POS_W  = ADDR_W + 1;   // half-open bounds may reach NODES

   // Field widths
   localparam int IDX_W = 10;
   localparam int VAL_W = 32;
   localparam int SUM_W = 43;

   // Command codes
   localparam logic CMD_SET   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_WALK,
      ST_QRY_LO,
      ST_QRY_HI,
      ST_QRY_FIN
   } state_type;

endpackage

[rtl/alternating_sign_range_sum_tree_core.sv]
// Alternating-sign range-sum tree: top level, sequencer, sum store and shared adder.
// Depends on asrst_pkg.
//
// The block keeps LEAVES signed positions in a one-port-write, one-port-read
// sum store of 2*LEAVES entries (leaves at LEAVES and up, each inner node the
// sum of its two children). One 43-bit adder is shared by the set and query
// steps. After reset a clearing pass writes zero to one node per cycle, over
// all 2*LEAVES nodes, before the first beat is taken. A set beat is accepted,
// then writes the leaf, then one parent per level while the sibling is read
// ahead. A query beat walks both bounds up the tree, the left bound and then
// the right bound at each level, because both bounds may need a read from the
// single read port; it then waits for the result register to free up. Sets
// with an index past the last leaf are dropped; a reversed or out-of-range
// query returns zero.
module alternating_sign_range_sum_tree_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic        [asrst_pkg::IDX_W-1:0]  req_first_index,
   input  logic        [asrst_pkg::IDX_W-1:0]  req_last_index,
   input  logic signed [asrst_pkg::VAL_W-1:0]  req_new_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [asrst_pkg::SUM_W-1:0]  rsp_range_sum
);
   import asrst_pkg::*;

   // Control registers
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rd_pend_ff, rd_pend_in;

   // Datapath registers
   logic [ADDR_W-1:0]   node_ff, node_in;
   logic [POS_W-1:0]    lo_ff, lo_in;
   logic [POS_W-1:0]    hi_ff, hi_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic                odd_ff, odd_in;
   logic [SUM_W-1:0]    rsp_data_ff, rsp_data_in;

   // Sum store
   logic [SUM_W-1:0]    mem [NODES];
   logic [SUM_W-1:0]    rd_data_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [SUM_W-1:0]    mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;

   // Shared adder
   logic [SUM_W-1:0]    add_a, add_b, add_out;
   logic                add_cin;

   // Accept-time decode
   logic                accept;
   logic                set_in_range;
   logic                qry_ok;
   logic [POS_W-1:0]    right_clamped;
   logic [ADDR_W-1:0]   parent;
   logic [SUM_W-1:0]    val_sext;
   logic                out_free;

   assign accept        = req_valid && (state_ff == ST_IDLE);
   assign set_in_range  = int'(req_first_index) < LEAVES;
   assign right_clamped = (int'(req_last_index) >= LEAVES) ? POS_W'(LEAVES - 1)
                                                            : POS_W'(req_last_index);
   assign qry_ok        = set_in_range && (req_first_index <= req_last_index);
   assign parent        = {1'b0, node_ff[ADDR_W-1:1]};
   assign val_sext      = {{(SUM_W-VAL_W){val_ff[VAL_W-1]}}, val_ff};
   assign out_free      = !rsp_valid_ff || rsp_ready;

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_data_ff;

   // Shared adder: a + b + cin; negation is ~a + 1
   assign add_out = add_a + add_b + SUM_W'(add_cin);

   always_comb begin
      add_a   = acc_ff;
      add_b   = '0;
      add_cin = 1'b0;
      case (state_ff)
         ST_UPD_LEAF: begin
            add_a   = val_sext ^ {SUM_W{odd_ff}};
            add_cin = odd_ff;
         end
         ST_UPD_WALK: begin
            add_b = rd_data_ff;
         end
         ST_QRY_LO, ST_QRY_HI: begin
            add_b = rd_pend_ff ? rd_data_ff : '0;
         end
         ST_QRY_FIN: begin
            add_a   = acc_ff ^ {SUM_W{odd_ff}};
            add_cin = odd_ff;
         end
         default: begin
            add_a = acc_ff;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(NODES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_QUERY)  state_in = ST_QRY_LO;
               else if (set_in_range)     state_in = ST_UPD_LEAF;
            end
         end
         ST_UPD_LEAF: state_in = ST_UPD_WALK;
         ST_UPD_WALK: begin
            if (parent == ADDR_W'(1)) state_in = ST_IDLE;
         end
         ST_QRY_LO: begin
            state_in = (lo_ff < hi_ff) ? ST_QRY_HI : ST_QRY_FIN;
         end
         ST_QRY_HI: state_in = ST_QRY_LO;
         ST_QRY_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath next values and store controls
   always_comb begin
      clr_in       = clr_ff;
      node_in      = node_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      val_in       = val_ff;
      odd_in       = odd_ff;
      rd_pend_in   = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = node_ff;
      mem_wdata    = add_out;
      mem_raddr    = node_ff ^ ADDR_W'(1);
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               odd_in  = req_first_index[0];
               val_in  = req_new_value;
               node_in = ADDR_W'(req_first_index) + ADDR_W'(LEAVES);
               acc_in  = '0;
               if (qry_ok) begin
                  lo_in = POS_W'(req_first_index) + POS_W'(LEAVES);
                  hi_in = right_clamped + POS_W'(LEAVES) + POS_W'(1);
               end else begin
                  lo_in = '0;
                  hi_in = '0;
               end
            end
         end
         // Write the leaf, read its sibling for the first parent
         ST_UPD_LEAF: begin
            mem_we    = 1'b1;
            mem_waddr = node_ff;
            acc_in    = add_out;
            mem_raddr = node_ff ^ ADDR_W'(1);
         end
         // One parent per cycle; sibling of the next parent read ahead
         ST_UPD_WALK: begin
            mem_we    = 1'b1;
            mem_waddr = parent;
            acc_in    = add_out;
            node_in   = parent;
            mem_raddr = parent ^ ADDR_W'(1);
         end
         // Left bound: take an odd node, then step right
         ST_QRY_LO: begin
            acc_in    = add_out;
            mem_raddr = lo_ff[ADDR_W-1:0];
            if (lo_ff < hi_ff && lo_ff[0]) begin
               rd_pend_in = 1'b1;
               lo_in      = lo_ff + POS_W'(1);
            end
         end
         // Right bound: take hi-1 when hi is odd, then climb a level
         ST_QRY_HI: begin
            acc_in     = add_out;
            mem_raddr  = {hi_ff[ADDR_W-1:1], 1'b0};
            rd_pend_in = hi_ff[0];
            lo_in      = lo_ff >> 1;
            hi_in      = hi_ff >> 1;
         end
         // Sign fix for an odd left bound, then load the result register
         ST_QRY_FIN: begin
            if (out_free) begin
               rsp_data_in  = add_out;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      acc_ff      <= acc_in;
      val_ff      <= val_in;
      odd_ff      <= odd_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sum store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

endmodule
